/* rtl/token_lexer_with_position_macros.svh */
// assertion macros used by the lexer rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef TOKEN_LEXER_WITH_POSITION_MACROS_SVH
`define TOKEN_LEXER_WITH_POSITION_MACROS_SVH

// same-cycle implication, checked out of reset
`define TLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlp_pkg.sv */
// shared types, constants and character tables of the lexer
// used by the lexer and the position tracker, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tlp_pkg;

    // text store sizing
    localparam int MAX_LEN = 16;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // position limits
    localparam int ROW_W = 16;
    localparam int COL_W = 12;
    localparam logic [ROW_W-1:0] ROW_MAX = '1;
    localparam logic [COL_W-1:0] COL_MAX = '1;

    // token kinds
    localparam logic [4:0] K_NEWLINE = 5'd0;
    localparam logic [4:0] K_LPAREN  = 5'd1;
    localparam logic [4:0] K_RPAREN  = 5'd2;
    localparam logic [4:0] K_COMMA   = 5'd3;
    localparam logic [4:0] K_VAR     = 5'd4;
    localparam logic [4:0] K_LBRACE  = 5'd5;
    localparam logic [4:0] K_RBRACE  = 5'd6;
    localparam logic [4:0] K_NUMBER  = 5'd7;
    localparam logic [4:0] K_EQUAL   = 5'd8;
    localparam logic [4:0] K_FUNC    = 5'd9;
    localparam logic [4:0] K_WORD    = 5'd10;
    localparam logic [4:0] K_KW0     = 5'd11;
    localparam logic [4:0] K_ERROR   = 5'd16;

    // error codes
    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_SYMBOL     = 3'd1;
    localparam logic [2:0] E_TOO_LONG   = 3'd2;
    localparam logic [2:0] E_EMPTY_VAR  = 3'd3;
    localparam logic [2:0] E_EMPTY_FUNC = 3'd4;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    // keyword table, padded to four bytes
    localparam int NUM_KW = 5;
    localparam logic [7:0] KW_TXT [NUM_KW][4] = '{
        '{"f", "u", "n", "c"},
        '{"i", 8'h00, 8'h00, 8'h00},
        '{"a", "d", "d", 8'h00},
        '{"c", "o", "p", "y"},
        '{"r", "e", "t", 8'h00}
    };
    localparam int KW_LEN [NUM_KW] = '{4, 1, 3, 4, 3};

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_WORD,
        MD_VAR,
        MD_NUM,
        MD_FUNC
    } t_mode;

    typedef enum logic [1:0] {
        ST_READY,
        ST_EMIT,
        ST_PEND,
        ST_HALT
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    // one result word
    typedef struct packed {
        logic [4:0]       kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [4:0]       len;
        logic [7:0]       txt_byte;
        logic [3:0]       idx;
        logic             last;
        logic [2:0]       err;
    } t_res;

    function automatic logic is_letter(logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_member(t_mode m, logic [7:0] c);
        logic r;
        case (m)
            MD_WORD: r = is_letter(c) || is_digit(c);
            MD_VAR:  r = is_letter(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT;
            MD_NUM:  r = is_digit(c);
            MD_FUNC: r = is_letter(c) || is_digit(c) || c == CH_UNDER;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_symbol(logic [7:0] c);
        return (c inside {CH_NL, CH_LPAREN, CH_RPAREN, CH_COMMA,
                          CH_LBRACE, CH_RBRACE, CH_EQUAL});
    endfunction

    function automatic logic [4:0] sym_kind(logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_NL:     k = K_NEWLINE;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_COMMA:  k = K_COMMA;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_EQUAL:  k = K_EQUAL;
            default:   k = K_ERROR;
        endcase
        return k;
    endfunction

    // does byte c at text position p still agree with keyword k
    function automatic logic kw_hit(int k, logic [IDX_W-1:0] p, logic [7:0] c);
        logic [1:0] s;
        s = 2'(p);
        return (int'(p) < KW_LEN[k]) && (KW_TXT[k][s] == c);
    endfunction

    // result without text bytes
    function automatic t_res mk_res(logic [4:0] kind, t_pos pos, logic [2:0] err);
        t_res r;
        r      = '0;
        r.kind = kind;
        r.row  = pos.row;
        r.col  = pos.col;
        r.last = 1'b1;
        r.err  = err;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/token_lexer_with_position.sv */
// Lexer with source position. Symbols and member characters are taken at one input word per
// cycle; a symbol result shows in the cycle after acceptance. A word shows in the cycle
// after its ending char, which is then handled from the pending state. A var, number or
// function token gives each text byte by a ram read and then the output register, then
// its ending char; a held output word stalls the input. Synchronous active-low reset clears
// mode, position and output valid; the text ram is not cleared, bytes are read once written.
`timescale 1ns / 1ps
`default_nettype none

`include "token_lexer_with_position_macros.svh"

module token_lexer_with_position (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_character,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_kind,
    output logic [15:0]      o_start_row,
    output logic [11:0]      o_start_col,
    output logic [4:0]       o_text_length,
    output logic [7:0]       o_text_byte,
    output logic [3:0]       o_text_index,
    output logic             o_last,
    output logic [2:0]       o_error_code
);

    import tlp_pkg::*;

    // control and token state
    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [NUM_KW-1:0] r_kw, n_kw;
    logic              r_nl_sent, n_nl_sent;
    t_pos              r_tok, n_tok;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_pend, n_pend;
    logic              r_pend_v, n_pend_v;
    logic              r_ovalid, n_ovalid;
    t_res              r_res, n_res;

    // decode
    logic              can_put, acc, rdy_acc;
    logic [7:0]        c_sel;
    logic              w_member, w_full, w_append, w_long, w_finish, w_empty;
    logic              w_start, w_ws, w_name, w_invalid, w_emit, w_last_byte;
    logic [4:0]        w_word_kind, w_text_kind;
    t_pos              pos_nx;

    // text ram ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [7:0]        ram_wdata, ram_rdata;

    tlp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN),
        .AW    (IDX_W)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    tlp_pos u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_append || w_start),
        .i_newline (w_start && c_sel == CH_NL),
        .o_pos_nx  (pos_nx)
    );

    // handshake and action decode
    assign can_put = !r_ovalid || !i_stall;
    assign o_stall = !((r_state == ST_READY && can_put) || r_state == ST_HALT);
    assign acc     = i_valid && !o_stall;
    assign rdy_acc = acc && r_state == ST_READY;
    assign c_sel   = (r_state == ST_PEND) ? r_pend : i_character;

    assign w_member = is_member(r_mode, i_character);
    assign w_full   = r_count == CNT_W'(MAX_LEN);
    assign w_append = rdy_acc && !i_command && r_mode != MD_IDLE && w_member && !w_full;
    assign w_long   = rdy_acc && !i_command && r_mode != MD_IDLE && w_member && w_full;
    assign w_finish = rdy_acc && r_mode != MD_IDLE && (i_command || !w_member);
    assign w_empty  = (r_mode == MD_VAR || r_mode == MD_FUNC) && r_count == '0;
    assign w_start  = (rdy_acc && !i_command && r_mode == MD_IDLE)
                   || (r_state == ST_PEND && can_put);

    assign w_ws      = c_sel == CH_SPACE || c_sel == CH_TAB;
    assign w_name    = is_letter(c_sel) || is_digit(c_sel) || c_sel == CH_MINUS;
    assign w_invalid = !w_ws && !w_name && c_sel != CH_PCT && c_sel != CH_DOLLAR
                    && !is_symbol(c_sel);

    assign w_emit      = r_state == ST_EMIT && r_rd_ok && can_put;
    assign w_last_byte = (CNT_W'(r_idx) + 1'b1) == r_count;

    // keyword pick, first match wins
    always_comb begin
        w_word_kind = K_WORD;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (r_kw[k] && int'(r_count) == KW_LEN[k]) begin
                w_word_kind = K_KW0 + 5'(k);
            end
        end
    end

    always_comb begin
        case (r_mode)
            MD_VAR:  w_text_kind = K_VAR;
            MD_NUM:  w_text_kind = K_NUMBER;
            default: w_text_kind = K_FUNC;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_READY: begin
                if (w_long) begin
                    n_state = ST_HALT;
                end else if (w_finish) begin
                    if (r_mode == MD_WORD) begin
                        n_state = i_command ? ST_READY : ST_PEND;
                    end else if (w_empty) begin
                        n_state = ST_HALT;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else if (w_start && w_invalid) begin
                    n_state = ST_HALT;
                end
            end
            ST_EMIT: begin
                if (w_emit && w_last_byte) begin
                    n_state = r_pend_v ? ST_PEND : ST_READY;
                end
            end
            ST_PEND: begin
                if (w_start) begin
                    n_state = w_invalid ? ST_HALT : ST_READY;
                end
            end
            ST_HALT: n_state = ST_HALT;
            default: n_state = ST_READY;
        endcase
    end

    // datapath and results
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_kw      = r_kw;
        n_nl_sent = r_nl_sent;
        n_tok     = r_tok;
        n_idx     = r_idx;
        n_rd_ok   = r_rd_ok;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_ovalid  = r_ovalid && i_stall;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_count[IDX_W-1:0];
        ram_wdata = i_character;

        // member character goes into the text store
        if (w_append) begin
            ram_we  = 1'b1;
            n_count = r_count + 1'b1;
            for (int k = 0; k < NUM_KW; k++) begin
                n_kw[k] = r_kw[k] && kw_hit(k, r_count[IDX_W-1:0], i_character);
            end
        end

        // text overflow
        if (w_long) begin
            n_ovalid = 1'b1;
            n_res    = mk_res(K_ERROR, r_tok, E_TOO_LONG);
        end

        // token end by a non-member character or by end of input
        if (w_finish) begin
            n_pend = i_character;
            if (r_mode == MD_WORD) begin
                n_ovalid  = 1'b1;
                n_res     = mk_res(w_word_kind, r_tok, E_NONE);
                n_mode    = MD_IDLE;
                n_count   = '0;
                n_nl_sent = 1'b0;
            end else if (w_empty) begin
                n_ovalid = 1'b1;
                n_res    = mk_res(K_ERROR, r_tok,
                                  (r_mode == MD_VAR) ? E_EMPTY_VAR : E_EMPTY_FUNC);
            end else begin
                n_idx    = '0;
                n_rd_ok  = 1'b0;
                n_pend_v = !i_command;
            end
        end

        // fresh character from idle
        if (w_start && !w_ws) begin
            n_tok   = pos_nx;
            n_count = '0;
            if (w_name) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = c_sel;
                n_count   = CNT_W'(1);
                n_mode    = is_letter(c_sel) ? MD_WORD : MD_NUM;
                for (int k = 0; k < NUM_KW; k++) begin
                    n_kw[k] = kw_hit(k, '0, c_sel);
                end
            end else if (c_sel == CH_PCT) begin
                n_mode = MD_VAR;
            end else if (c_sel == CH_DOLLAR) begin
                n_mode = MD_FUNC;
            end else if (w_invalid) begin
                n_ovalid = 1'b1;
                n_res    = mk_res(K_ERROR, pos_nx, E_SYMBOL);
            end else if (!(c_sel == CH_NL && r_nl_sent)) begin
                n_ovalid  = 1'b1;
                n_res     = mk_res(sym_kind(c_sel), pos_nx, E_NONE);
                n_nl_sent = c_sel == CH_NL;
            end
        end

        // text byte streaming: read, then present
        if (r_state == ST_EMIT && !r_rd_ok) begin
            n_rd_ok = 1'b1;
        end
        if (w_emit) begin
            n_ovalid       = 1'b1;
            n_res          = mk_res(w_text_kind, r_tok, E_NONE);
            n_res.len      = 5'(r_count);
            n_res.txt_byte = ram_rdata;
            n_res.idx      = 4'(r_idx);
            n_res.last     = w_last_byte;
            n_idx          = r_idx + 1'b1;
            n_rd_ok        = 1'b0;
            if (w_last_byte) begin
                n_mode    = MD_IDLE;
                n_count   = '0;
                n_nl_sent = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_READY;
            r_mode    <= MD_IDLE;
            r_count   <= '0;
            r_kw      <= '0;
            r_nl_sent <= 1'b0;
            r_tok     <= '{row: ROW_W'(1), col: '0};
            r_idx     <= '0;
            r_rd_ok   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_kw      <= n_kw;
            r_nl_sent <= n_nl_sent;
            r_tok     <= n_tok;
            r_idx     <= n_idx;
            r_rd_ok   <= n_rd_ok;
            r_pend_v  <= n_pend_v;
            r_ovalid  <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    assign o_valid       = r_ovalid;
    assign o_kind        = r_res.kind;
    assign o_start_row   = r_res.row;
    assign o_start_col   = r_res.col;
    assign o_text_length = r_res.len;
    assign o_text_byte   = r_res.txt_byte;
    assign o_text_index  = r_res.idx;
    assign o_last        = r_res.last;
    assign o_error_code  = r_res.err;

    // checks
    `TLP_ASSERT_NXT(a_halt_sticky, r_state == ST_HALT, r_state == ST_HALT, "halt left")
    `TLP_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_LEN), "text count overflow")
    `TLP_ASSERT_IMP(a_emit_nonempty, r_state == ST_EMIT, r_count != '0, "emit of empty text")
    `TLP_ASSERT_IMP(a_emit_mode, r_state == ST_EMIT,
        r_mode == MD_VAR || r_mode == MD_NUM || r_mode == MD_FUNC, "emit in wrong mode")

endmodule

`default_nettype wire

/* rtl/tlp_ram.sv */
// generic single-write, single-read ram with registered read data
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module tlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/tlp_pos.sv */
// source position tracker: saturating row and column with deferred row bump
// depends on tlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlp_pos (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_newline,
    output tlp_pkg::t_pos      o_pos_nx
);

    import tlp_pkg::*;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_bump, n_bump;

    // position after the character now being handled
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_bump = r_bump;
        if (r_bump) begin
            if (r_row != ROW_MAX) begin
                n_row = r_row + 1'b1;
            end
            n_col  = COL_W'(1);
            n_bump = 1'b0;
        end else if (r_col != COL_MAX) begin
            n_col = r_col + 1'b1;
        end
        if (i_newline) begin
            n_bump = 1'b1;
        end
    end

    assign o_pos_nx = '{row: n_row, col: n_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= ROW_W'(1);
            r_col  <= '0;
            r_bump <= 1'b0;
        end else if (i_step) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_bump <= n_bump;
        end
    end

endmodule

`default_nettype wire
